// ===== src/m7atm_pkg.sv =====
// shared widths, register codes, reset values and types of the mode 7 mapper
`default_nettype none
package m7atm_pkg;

    localparam int COEF_W    = 24;
    localparam int CTR_W     = 8;
    localparam int HZ_W      = 10;
    localparam int COORD_W   = 8;
    localparam int IDX_W     = 12;
    localparam int TEXEL_W   = 16;
    localparam int SCR_W     = 16;
    localparam int CFG_IDX_W = 3;

    // offsets from centre, products, numerators
    localparam int OFS_W  = COORD_W + 1;
    localparam int PROD_W = COEF_W + OFS_W;
    localparam int NUM_W  = PROD_W + 2;
    // numerator magnitude after dropping the 8 fraction bits
    localparam int MAG_W  = NUM_W - 9;
    localparam int DIV_W  = COORD_W + 3;
    localparam int DIV_STAGES = MAG_W;

    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;

    localparam int TEX_SIDE_DEF     = 64;
    localparam int SCREEN_WIDTH_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_C   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZON  = 3'd6;

    localparam logic [COEF_W-1:0] RST_COEF_A   = 24'd256;
    localparam logic [COEF_W-1:0] RST_COEF_B   = 24'd0;
    localparam logic [COEF_W-1:0] RST_COEF_C   = 24'd0;
    localparam logic [COEF_W-1:0] RST_COEF_D   = 24'd256;
    localparam logic [CTR_W-1:0]  RST_CENTER_X = 8'd128;
    localparam logic [CTR_W-1:0]  RST_CENTER_Y = 8'd122;
    localparam logic [HZ_W-1:0]   RST_HORIZON  = 10'd1;

    typedef struct packed {
        logic [MAG_W-1:0] mag_u;
        logic [MAG_W-1:0] mag_v;
        logic [DIV_W-1:0] divisor;
        logic             neg_u;
        logic             neg_v;
    } t_div_req;

    typedef struct packed {
        logic [MAG_W-1:0] quo_u;
        logic [MAG_W-1:0] quo_v;
        logic             neg_u;
        logic             neg_v;
    } t_div_res;

endpackage
`default_nettype wire

// ===== src/m7atm_if.sv =====
// handshake channels of the mode 7 mapper
`default_nettype none
interface m7atm_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [m7atm_pkg::COORD_W-1:0]     pixel_x;
    logic [m7atm_pkg::COORD_W-1:0]     pixel_y;
    logic [m7atm_pkg::IDX_W-1:0]       texel_index;
    logic [m7atm_pkg::TEXEL_W-1:0]     texel_value;

    modport source (output valid, func, pixel_x, pixel_y, texel_index, texel_value,
                    input ready);
    modport sink (input valid, func, pixel_x, pixel_y, texel_index, texel_value,
                  output ready);
endinterface

interface m7atm_out_if;
    logic                              valid;
    logic                              ready;
    logic [m7atm_pkg::TEXEL_W-1:0]     pixel_color;
    logic [m7atm_pkg::SCR_W-1:0]       screen_address;

    modport source (output valid, pixel_color, screen_address, input ready);
    modport sink (input valid, pixel_color, screen_address, output ready);
endinterface
`default_nettype wire

// ===== src/m7atm_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module m7atm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule
`default_nettype wire

// ===== src/m7atm_div.sv =====
// pipelined restoring divider, one quotient bit per stage, two lanes
`default_nettype none
module m7atm_div (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire m7atm_pkg::t_div_req i_req,
    output m7atm_pkg::t_div_res      o_res
);

    localparam int N  = m7atm_pkg::DIV_STAGES;
    localparam int MW = m7atm_pkg::MAG_W;
    localparam int DW = m7atm_pkg::DIV_W;

    logic [DW-1:0] r_rem_u [1:N];
    logic [DW-1:0] r_rem_v [1:N];
    logic [MW-1:0] r_num_u [1:N];
    logic [MW-1:0] r_num_v [1:N];
    logic [MW-1:0] r_quo_u [1:N];
    logic [MW-1:0] r_quo_v [1:N];
    logic [DW-1:0] r_dvs   [1:N];
    logic          r_neg_u [1:N];
    logic          r_neg_v [1:N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [DW-1:0] src_rem_u, src_rem_v, src_dvs;
        logic [MW-1:0] src_num_u, src_num_v, src_quo_u, src_quo_v;
        logic          src_neg_u, src_neg_v;
        logic [DW:0]   trial_u, trial_v, diff_u, diff_v;
        logic          ge_u, ge_v;

        if (s == 0) begin : g_first
            assign src_rem_u = '0;
            assign src_rem_v = '0;
            assign src_num_u = i_req.mag_u;
            assign src_num_v = i_req.mag_v;
            assign src_quo_u = '0;
            assign src_quo_v = '0;
            assign src_dvs   = i_req.divisor;
            assign src_neg_u = i_req.neg_u;
            assign src_neg_v = i_req.neg_v;
        end else begin : g_next
            assign src_rem_u = r_rem_u[s];
            assign src_rem_v = r_rem_v[s];
            assign src_num_u = r_num_u[s];
            assign src_num_v = r_num_v[s];
            assign src_quo_u = r_quo_u[s];
            assign src_quo_v = r_quo_v[s];
            assign src_dvs   = r_dvs[s];
            assign src_neg_u = r_neg_u[s];
            assign src_neg_v = r_neg_v[s];
        end

        // shift in the next numerator bit and try the divisor
        assign trial_u = {src_rem_u, src_num_u[MW-1]};
        assign trial_v = {src_rem_v, src_num_v[MW-1]};
        assign diff_u  = trial_u - {1'b0, src_dvs};
        assign diff_v  = trial_v - {1'b0, src_dvs};
        assign ge_u    = trial_u >= {1'b0, src_dvs};
        assign ge_v    = trial_v >= {1'b0, src_dvs};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_u[s+1] <= ge_u ? diff_u[DW-1:0] : trial_u[DW-1:0];
                r_rem_v[s+1] <= ge_v ? diff_v[DW-1:0] : trial_v[DW-1:0];
                r_num_u[s+1] <= {src_num_u[MW-2:0], 1'b0};
                r_num_v[s+1] <= {src_num_v[MW-2:0], 1'b0};
                r_quo_u[s+1] <= {src_quo_u[MW-2:0], ge_u};
                r_quo_v[s+1] <= {src_quo_v[MW-2:0], ge_v};
                r_dvs[s+1]   <= src_dvs;
                r_neg_u[s+1] <= src_neg_u;
                r_neg_v[s+1] <= src_neg_v;
            end
        end
    end

    assign o_res.quo_u = r_quo_u[N];
    assign o_res.quo_v = r_quo_v[N];
    assign o_res.neg_u = r_neg_u[N];
    assign o_res.neg_v = r_neg_v[N];

endmodule
`default_nettype wire

// ===== src/mode7_affine_texture_mapper_unit.sv =====
// top level of the mode 7 affine texture mapper
//
// channel  dir  word
// i_in     in   func, pixel_x, pixel_y, texel_index, texel_value
// o_out    out  pixel_color, screen_address (one per pixel word, none per load)
// i_cfg_*  in   register writes: coefficients, centre, horizon
//
// one word accepted per clock while the pipe is not held; a pixel result passes
// through stages 0 to 2, the divider stages and the output register
// the divider pipeline retires one quotient bit per stage
// loads travel down the same pipe and write the texture ram in the stage where
// pixels read it, so reads and writes keep arrival order on one port
// the whole pipe holds while a result waits and the output side is not ready
// synchronous reset clears valid bits and sets the configuration registers to
// their reset values; the texture ram is not cleared
`default_nettype none
module mode7_affine_texture_mapper_unit #(
    parameter int TEX_SIDE     = m7atm_pkg::TEX_SIDE_DEF,
    parameter int SCREEN_WIDTH = m7atm_pkg::SCREEN_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    m7atm_in_if.sink                               i_in,
    m7atm_out_if.source                            o_out,
    input  wire logic                              i_cfg_we,
    input  wire logic [m7atm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [m7atm_pkg::COEF_W-1:0]      i_cfg_wdata
);

    localparam int TEX_BITS = $clog2(TEX_SIDE);
    localparam int N        = m7atm_pkg::DIV_STAGES;
    localparam int NW       = m7atm_pkg::NUM_W;
    localparam int PW       = m7atm_pkg::PROD_W;
    localparam int OW       = m7atm_pkg::OFS_W;

    // sideband that rides alongside the arithmetic
    typedef struct packed {
        logic                              func;
        logic [m7atm_pkg::SCR_W-1:0]       scr;
        logic [m7atm_pkg::IDX_W-1:0]       idx;
        logic [m7atm_pkg::TEXEL_W-1:0]     val;
    } t_side;

    // configuration registers
    logic signed [m7atm_pkg::COEF_W-1:0] r_coef_a, r_coef_b, r_coef_c, r_coef_d;
    logic [m7atm_pkg::CTR_W-1:0]         r_center_x, r_center_y;
    logic [m7atm_pkg::HZ_W-1:0]          r_horizon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a   <= m7atm_pkg::RST_COEF_A;
            r_coef_b   <= m7atm_pkg::RST_COEF_B;
            r_coef_c   <= m7atm_pkg::RST_COEF_C;
            r_coef_d   <= m7atm_pkg::RST_COEF_D;
            r_center_x <= m7atm_pkg::RST_CENTER_X;
            r_center_y <= m7atm_pkg::RST_CENTER_Y;
            r_horizon  <= m7atm_pkg::RST_HORIZON;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                m7atm_pkg::REG_COEF_A:   r_coef_a   <= i_cfg_wdata;
                m7atm_pkg::REG_COEF_B:   r_coef_b   <= i_cfg_wdata;
                m7atm_pkg::REG_COEF_C:   r_coef_c   <= i_cfg_wdata;
                m7atm_pkg::REG_COEF_D:   r_coef_d   <= i_cfg_wdata;
                m7atm_pkg::REG_CENTER_X: r_center_x <= i_cfg_wdata[m7atm_pkg::CTR_W-1:0];
                m7atm_pkg::REG_CENTER_Y: r_center_y <= i_cfg_wdata[m7atm_pkg::CTR_W-1:0];
                m7atm_pkg::REG_HORIZON:  r_horizon  <= i_cfg_wdata[m7atm_pkg::HZ_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves whenever the output register can take a word
    logic en;
    logic r_out_valid;
    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // stage 0: offsets from centre, divisor, screen address
    logic                              r_s0_vld;
    t_side                             r_s0_side;
    logic signed [OW-1:0]              r_s0_dx, r_s0_dy;
    logic [m7atm_pkg::DIV_W-1:0]       r_s0_dvs;
    logic [m7atm_pkg::HZ_W-1:0]        hz_eff;
    logic [31:0]                       scr_full;

    // a zero horizon counts as one so the divisor never vanishes
    assign hz_eff   = (r_horizon == '0) ? m7atm_pkg::HZ_W'(1) : r_horizon;
    assign scr_full = 32'(i_in.pixel_y) * 32'(SCREEN_WIDTH) + 32'(i_in.pixel_x);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side.func <= i_in.func;
            r_s0_side.scr  <= scr_full[m7atm_pkg::SCR_W-1:0];
            r_s0_side.idx  <= i_in.texel_index;
            r_s0_side.val  <= i_in.texel_value;
            r_s0_dx  <= OW'({1'b0, i_in.pixel_x}) - OW'({1'b0, r_center_x});
            r_s0_dy  <= OW'({1'b0, i_in.pixel_y}) - OW'({1'b0, r_center_y});
            r_s0_dvs <= m7atm_pkg::DIV_W'(i_in.pixel_y) + m7atm_pkg::DIV_W'(hz_eff);
        end
    end

    // stage 1: the four coefficient products
    logic                         r_s1_vld;
    t_side                        r_s1_side;
    logic signed [PW-1:0]         r_s1_pa, r_s1_pb, r_s1_pc, r_s1_pd;
    logic [m7atm_pkg::DIV_W-1:0]  r_s1_dvs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= r_s0_side;
            r_s1_dvs  <= r_s0_dvs;
            r_s1_pa   <= r_coef_a * r_s0_dx;
            r_s1_pb   <= r_coef_b * r_s0_dy;
            r_s1_pc   <= r_coef_c * r_s0_dx;
            r_s1_pd   <= r_coef_d * r_s0_dy;
        end
    end

    // stage 2: numerators in q.8, centre added back
    logic                         r_s2_vld;
    t_side                        r_s2_side;
    logic signed [NW-1:0]         r_s2_nu, r_s2_nv;
    logic [m7atm_pkg::DIV_W-1:0]  r_s2_dvs;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= r_s1_side;
            r_s2_dvs  <= r_s1_dvs;
            r_s2_nu   <= NW'(r_s1_pa) + NW'(r_s1_pb) + NW'({r_center_x, 8'b0});
            r_s2_nv   <= NW'(r_s1_pc) + NW'(r_s1_pd) + NW'({r_center_y, 8'b0});
        end
    end

    // divide magnitudes; truncation toward zero follows from sign and magnitude
    logic [NW-1:0]        abs_u, abs_v;
    m7atm_pkg::t_div_req  div_req;
    m7atm_pkg::t_div_res  div_res;

    assign abs_u           = r_s2_nu[NW-1] ? -r_s2_nu : r_s2_nu;
    assign abs_v           = r_s2_nv[NW-1] ? -r_s2_nv : r_s2_nv;
    assign div_req.mag_u   = abs_u[NW-2:8];
    assign div_req.mag_v   = abs_v[NW-2:8];
    assign div_req.divisor = r_s2_dvs;
    assign div_req.neg_u   = r_s2_nu[NW-1];
    assign div_req.neg_v   = r_s2_nv[NW-1];

    m7atm_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_req (div_req),
        .o_res (div_res)
    );

    // sideband delay line matching the divider
    logic  r_dl_vld  [1:N];
    t_side r_dl_side [1:N];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_side[1] <= r_s2_side;
            for (int k = 2; k <= N; k++) begin
                r_dl_side[k] <= r_dl_side[k-1];
            end
        end
    end

    // valid bits of the whole pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            for (int k = 1; k <= N; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_s0_vld    <= i_in.valid;
            r_s1_vld    <= r_s0_vld;
            r_s2_vld    <= r_s1_vld;
            r_dl_vld[1] <= r_s2_vld;
            for (int k = 2; k <= N; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
        end
    end

    // wrap both quotients to the texture side by their low bits
    logic [m7atm_pkg::MAG_W-1:0]     q_u, q_v;
    logic [2*TEX_BITS-1:0]           tex_cat;
    logic [31:0]                     tex_full;
    logic [m7atm_pkg::STORE_AW-1:0]  ram_addr;
    logic                            ram_we;
    t_side                           tail;

    assign tail     = r_dl_side[N];
    assign q_u      = div_res.neg_u ? -div_res.quo_u : div_res.quo_u;
    assign q_v      = div_res.neg_v ? -div_res.quo_v : div_res.quo_v;
    assign tex_cat  = {q_v[TEX_BITS-1:0], q_u[TEX_BITS-1:0]};
    assign tex_full = 32'(tex_cat);
    assign ram_addr = tail.func ? tail.idx : tex_full[m7atm_pkg::STORE_AW-1:0];
    assign ram_we   = en && r_dl_vld[N] && tail.func;

    m7atm_ram #(
        .WIDTH (m7atm_pkg::TEXEL_W),
        .DEPTH (m7atm_pkg::STORE_DEPTH)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (en),
        .i_addr  (ram_addr),
        .i_wdata (tail.val),
        .o_rdata (o_out.pixel_color)
    );

    // output register; the ram read data holds with it while stalled
    logic [m7atm_pkg::SCR_W-1:0] r_out_scr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dl_vld[N] && !tail.func;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_scr <= tail.scr;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.screen_address = r_out_scr;

endmodule
`default_nettype wire
